### rtl/pstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstg_pkg - shared types and codes for the polynomial sine tone generator
// Holds port widths, register indexes, the controller-to-datapath command
// word and its op and term codes.
// ----------------------------------------------------------------------------
package pstg_pkg;

    // Port widths
    localparam int SAMPLE_W    = 16;
    localparam int PEAK_W      = 15;
    localparam int STEP_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_LEVEL = 2'd1;

    // Datapath operations, one per cycle
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_START     = 4'd1;  // latch phase, advance accumulator
    localparam logic [3:0] OP_MUL_ANG   = 4'd2;  // |p| * pi/4
    localparam logic [3:0] OP_MUL_X2    = 4'd3;  // angle squared
    localparam logic [3:0] OP_LOAD_X2   = 4'd4;  // keep x^2, first dividend
    localparam logic [3:0] OP_MUL_RECIP = 4'd5;  // dividend * reciprocal
    localparam logic [3:0] OP_MUL_QK    = 4'd6;  // quotient estimate * divisor
    localparam logic [3:0] OP_CORRECT   = 4'd7;  // fix quotient, form Horner term
    localparam logic [3:0] OP_MUL_XH    = 4'd8;  // x^2 * h
    localparam logic [3:0] OP_LOAD_V    = 4'd9;  // keep next dividend
    localparam logic [3:0] OP_MUL_AH    = 4'd10; // angle * h
    localparam logic [3:0] OP_MUL_PK    = 4'd11; // sine * peak level
    localparam logic [3:0] OP_FINISH    = 4'd12; // saturate, sign, load output

    // Horner term index, innermost first
    localparam logic [1:0] TERM_72 = 2'd0;
    localparam logic [1:0] TERM_42 = 2'd1;
    localparam logic [1:0] TERM_20 = 2'd2;
    localparam logic [1:0] TERM_6  = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] term;
    } pstg_cmd_t;

endpackage

### rtl/pstg_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstg_dpath - datapath of the polynomial sine tone generator
// Phase accumulator, configuration registers, one shared 33x32 multiplier
// with its product register, and the working registers of the Horner series.
// ----------------------------------------------------------------------------
module pstg_dpath #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pstg_pkg::pstg_cmd_t                  cmd,
    input  logic                                 restart,
    input  logic                                 buffer_end,
    input  logic                                 cfg_write,
    input  logic [pstg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pstg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [pstg_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [pstg_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                 last
);

    localparam logic [31:0] PHASE_STEP_RST = 32'd35791394;
    localparam logic [14:0] PEAK_LEVEL_RST = 15'd9830;
    localparam logic [31:0] PI_OVER_4_Q32  = 32'hC90F_DAA2;
    localparam logic [31:0] ONE_Q29        = 32'h2000_0000;
    localparam logic [16:0] SAMPLE_MAX     = 17'd32767;

    // Divisor, reciprocal floor(2^s/K) and shift s for each Horner term
    function automatic logic [31:0] term_divisor(input logic [1:0] term);
        logic [31:0] d;
        case (term)
            pstg_pkg::TERM_72: d = 32'd72;
            pstg_pkg::TERM_42: d = 32'd42;
            pstg_pkg::TERM_20: d = 32'd20;
            pstg_pkg::TERM_6:  d = 32'd6;
            default:           d = 32'd0;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] term_recip(input logic [1:0] term);
        logic [31:0] m;
        case (term)
            pstg_pkg::TERM_72: m = 32'd3817748707;
            pstg_pkg::TERM_42: m = 32'd3272356035;
            pstg_pkg::TERM_20: m = 32'd3435973836;
            pstg_pkg::TERM_6:  m = 32'd2863311530;
            default:           m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] term_shift(input logic [1:0] term);
        logic [5:0] s;
        case (term)
            pstg_pkg::TERM_72: s = 6'd38;
            pstg_pkg::TERM_42: s = 6'd37;
            pstg_pkg::TERM_20: s = 6'd36;
            pstg_pkg::TERM_6:  s = 6'd34;
            default:           s = 6'd0;
        endcase
        return s;
    endfunction

    // Control state and configuration
    logic [31:0]                  phase_step_reg, phase_step_next;
    logic [14:0]                  peak_level_reg, peak_level_next;
    logic [PHASE_BITS-1:0]        phase_acc_reg,  phase_acc_next;

    // Working registers
    logic [31:0]                  mag_reg,        mag_next;
    logic                         neg_reg,        neg_next;
    logic                         frame_last_reg, frame_last_next;
    logic [30:0]                  ang_reg,        ang_next;
    logic [32:0]                  x2_reg,         x2_next;
    logic [32:0]                  v_reg,          v_next;
    logic [30:0]                  q_reg,          q_next;
    logic [29:0]                  h_reg,          h_next;
    logic [64:0]                  prod_reg,       prod_next;
    logic [15:0]                  sample_reg,     sample_next;
    logic                         last_reg,       last_next;

    logic [PHASE_BITS-1:0]        phase_cur;
    logic [31:0]                  phase_top;
    logic [32:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [63:0]                  mul_lo;
    logic [64:0]                  mul_prod;
    logic [64:0]                  q_shifted;
    logic [30:0]                  q_est;
    logic [32:0]                  rem;
    logic                         q_carry;
    logic [31:0]                  h_calc;
    logic [16:0]                  smp_mag;
    logic [14:0]                  smp_sat;
    logic [15:0]                  smp_pos;

    // Phase of this frame, top 32 bits read as a signed fraction of a turn
    assign phase_cur = restart ? '0 : phase_acc_reg;

    generate
        if (PHASE_BITS >= 32) begin : g_top_wide
            assign phase_top = phase_cur[PHASE_BITS-1 -: 32];
        end else begin : g_top_narrow
            assign phase_top = {phase_cur, {(32-PHASE_BITS){1'b0}}};
        end
    endgenerate

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pstg_pkg::OP_MUL_ANG:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = PI_OVER_4_Q32;
            end
            pstg_pkg::OP_MUL_X2:
            begin
                mul_a = {2'b00, prod_reg[62:32]};
                mul_b = {1'b0, prod_reg[62:32]};
            end
            pstg_pkg::OP_MUL_RECIP:
            begin
                mul_a = v_reg;
                mul_b = term_recip(cmd.term);
            end
            pstg_pkg::OP_MUL_QK:
            begin
                mul_a = {2'b00, q_est};
                mul_b = term_divisor(cmd.term);
            end
            pstg_pkg::OP_MUL_XH:
            begin
                mul_a = x2_reg;
                mul_b = {2'b00, h_reg};
            end
            pstg_pkg::OP_MUL_AH:
            begin
                mul_a = {2'b00, ang_reg};
                mul_b = {2'b00, h_reg};
            end
            pstg_pkg::OP_MUL_PK:
            begin
                mul_a = prod_reg[61:29];
                mul_b = {17'd0, peak_level_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // 32x32 core plus the top bit of A as a shifted add
    assign mul_lo   = 64'(mul_a[31:0]) * 64'(mul_b);
    assign mul_prod = {1'b0, mul_lo} + (mul_a[32] ? {1'b0, mul_b, 32'd0} : 65'd0);

    // Quotient estimate from the reciprocal product, low by at most one
    assign q_shifted = prod_reg >> term_shift(cmd.term);
    assign q_est     = q_shifted[30:0];

    // Correction: one more if the remainder still holds the divisor
    assign rem     = v_reg - prod_reg[32:0];
    assign q_carry = (rem >= {1'b0, term_divisor(cmd.term)});
    assign h_calc  = ONE_Q29 - {1'b0, q_reg} - {31'd0, q_carry};

    // Output scaling: truncate, saturate magnitude, then apply sign
    assign smp_mag = prod_reg[45:29];
    assign smp_sat = (smp_mag > SAMPLE_MAX) ? SAMPLE_MAX[14:0] : smp_mag[14:0];
    assign smp_pos = {1'b0, smp_sat};

    // Next-state logic
    always_comb
    begin
        phase_step_next = phase_step_reg;
        peak_level_next = peak_level_reg;
        phase_acc_next  = phase_acc_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        frame_last_next = frame_last_reg;
        ang_next        = ang_reg;
        x2_next         = x2_reg;
        v_next          = v_reg;
        q_next          = q_reg;
        h_next          = h_reg;
        prod_next       = prod_reg;
        sample_next     = sample_reg;
        last_next       = last_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                pstg_pkg::REG_PHASE_STEP: phase_step_next = cfg_data;
                pstg_pkg::REG_PEAK_LEVEL: peak_level_next = cfg_data[14:0];
                default:                  ;
            endcase
        end

        case (cmd.op)
            pstg_pkg::OP_START:
            begin
                neg_next        = phase_top[31];
                mag_next        = phase_top[31] ? (32'd0 - phase_top) : phase_top;
                frame_last_next = buffer_end;
                phase_acc_next  = phase_cur + PHASE_BITS'(phase_step_reg);
            end
            pstg_pkg::OP_MUL_ANG,
            pstg_pkg::OP_MUL_RECIP,
            pstg_pkg::OP_MUL_XH,
            pstg_pkg::OP_MUL_AH,
            pstg_pkg::OP_MUL_PK:
            begin
                prod_next = mul_prod;
            end
            pstg_pkg::OP_MUL_X2:
            begin
                ang_next  = prod_reg[62:32];
                prod_next = mul_prod;
            end
            pstg_pkg::OP_LOAD_X2:
            begin
                x2_next = prod_reg[61:29];
                v_next  = prod_reg[61:29];
            end
            pstg_pkg::OP_MUL_QK:
            begin
                q_next    = q_est;
                prod_next = mul_prod;
            end
            pstg_pkg::OP_CORRECT:
            begin
                h_next = h_calc[29:0];
            end
            pstg_pkg::OP_LOAD_V:
            begin
                v_next = prod_reg[61:29];
            end
            pstg_pkg::OP_FINISH:
            begin
                sample_next = neg_reg ? (16'd0 - smp_pos) : smp_pos;
                last_next   = frame_last_reg;
            end
            default: ;
        endcase
    end

    // Configuration and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            peak_level_reg <= PEAK_LEVEL_RST;
            phase_acc_reg  <= '0;
        end
        else
        begin
            phase_step_reg <= phase_step_next;
            peak_level_reg <= peak_level_next;
            phase_acc_reg  <= phase_acc_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        frame_last_reg <= frame_last_next;
        ang_reg        <= ang_next;
        x2_reg         <= x2_next;
        v_reg          <= v_next;
        q_reg          <= q_next;
        h_reg          <= h_next;
        prod_reg       <= prod_next;
        sample_reg     <= sample_next;
        last_reg       <= last_next;
    end

    assign left_sample  = sample_reg;
    assign right_sample = sample_reg;
    assign last         = last_reg;

endmodule

### rtl/pstg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstg_ctrl - sequencer of the polynomial sine tone generator
// Steps the datapath through one frame, counts the Horner terms and owns
// both handshakes, including the output holding slot.
// ----------------------------------------------------------------------------
module pstg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output pstg_pkg::pstg_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ANG   = 4'd1;
    localparam logic [3:0] ST_X2    = 4'd2;
    localparam logic [3:0] ST_LDX2  = 4'd3;
    localparam logic [3:0] ST_RECIP = 4'd4;
    localparam logic [3:0] ST_QK    = 4'd5;
    localparam logic [3:0] ST_CORR  = 4'd6;
    localparam logic [3:0] ST_XH    = 4'd7;
    localparam logic [3:0] ST_LDV   = 4'd8;
    localparam logic [3:0] ST_AH    = 4'd9;
    localparam logic [3:0] ST_PK    = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    logic [3:0] state_reg,     state_next;
    logic [1:0] term_reg,      term_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] cmd_op;

    // Frame sequence
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd_op     = pstg_pkg::OP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_op     = pstg_pkg::OP_START;
                    term_next  = pstg_pkg::TERM_72;
                    state_next = ST_ANG;
                end
            end
            ST_ANG:
            begin
                cmd_op     = pstg_pkg::OP_MUL_ANG;
                state_next = ST_X2;
            end
            ST_X2:
            begin
                cmd_op     = pstg_pkg::OP_MUL_X2;
                state_next = ST_LDX2;
            end
            ST_LDX2:
            begin
                cmd_op     = pstg_pkg::OP_LOAD_X2;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd_op     = pstg_pkg::OP_MUL_RECIP;
                state_next = ST_QK;
            end
            ST_QK:
            begin
                cmd_op     = pstg_pkg::OP_MUL_QK;
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                cmd_op = pstg_pkg::OP_CORRECT;
                if (term_reg == pstg_pkg::TERM_6)
                begin
                    state_next = ST_AH;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_XH;
                end
            end
            ST_XH:
            begin
                cmd_op     = pstg_pkg::OP_MUL_XH;
                state_next = ST_LDV;
            end
            ST_LDV:
            begin
                cmd_op     = pstg_pkg::OP_LOAD_V;
                state_next = ST_RECIP;
            end
            ST_AH:
            begin
                cmd_op     = pstg_pkg::OP_MUL_AH;
                state_next = ST_PK;
            end
            ST_PK:
            begin
                cmd_op     = pstg_pkg::OP_MUL_PK;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait here while the previous result is still held
                if (!out_valid_reg || !out_stall)
                begin
                    cmd_op     = pstg_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot: set by a finish, cleared when the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_op == pstg_pkg::OP_FINISH)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            term_reg      <= pstg_pkg::TERM_72;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.op    = cmd_op;
    assign cmd.term  = term_reg;

`ifndef SYNTH
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_op == pstg_pkg::OP_FINISH) |-> (!out_valid_reg || !out_stall))
        else $error("finish overwrote a held result");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd_op == pstg_pkg::OP_FINISH))
        else $error("result shown without a finish");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_ANG && term_reg == pstg_pkg::TERM_72))
        else $error("accepted frame did not start the series");

    a_last_term_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORR && term_reg == pstg_pkg::TERM_6) |=> (state_reg == ST_AH))
        else $error("series did not end after the last term");
`endif

endmodule

### rtl/polynomial_sine_tone_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_sine_tone_generator_top - Taylor series sine tone generator
// Produces one stereo frame per input transaction from a phase accumulator,
// a 9th-order sine series in Q.29 fixed point and a peak level scale.
// ----------------------------------------------------------------------------
// The length of a frame is set by the single shared 33x32 multiplier: each
// frame runs 15 products through it back to end (angle, square, four Horner
// terms each divided by a reciprocal multiply with one correction, and the
// final two scalings). The next input is taken as soon as the sequencer is
// free, even while the last result still waits in the output register; a
// frame only pauses at its last step if that register is still held.
// phase_step and peak_level may be written at any time the block is idle.
module polynomial_sine_tone_generator_top #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    input  logic                                 buffer_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pstg_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [pstg_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                 last,
    input  logic                                 cfg_write,
    input  logic [pstg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pstg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pstg_pkg::pstg_cmd_t cmd;

    // Sequencer and handshakes
    pstg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Arithmetic and state
    pstg_dpath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .restart      (restart),
        .buffer_end   (buffer_end),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last         (last)
    );

endmodule
